// ===== hw/rtl/spfm_pkg.sv =====
`timescale 1ns / 1ps

package spfm_pkg;

	// sizes
	localparam int SAMPLE_BITS = 12;
	localparam int MAX_WINDOW  = 128;
	localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W       = $clog2(MAX_WINDOW);
	localparam int PERIOD_W    = 16;
	localparam int STEP_W      = 10;
	localparam int CLK_W       = 26;
	localparam int FREQ_W      = 25;
	localparam int DIVISOR_W   = PERIOD_W + WIN_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 26;
	localparam int MATCH_W     = SAMPLE_BITS + 7;

	// register reset values
	localparam logic [7:0]          RST_WINDOW  = 8'd100;
	localparam logic [PERIOD_W-1:0] RST_START   = 16'd400;
	localparam logic [STEP_W-1:0]   RST_STEP    = 10'd4;
	localparam logic [PERIOD_W-1:0] RST_FLOOR   = 16'd40;
	localparam logic [PERIOD_W-1:0] RST_CEILING = 16'd40000;
	localparam logic [CLK_W-1:0]    RST_CLOCK   = 26'd4000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW  = 3'd0,
		REG_START   = 3'd1,
		REG_STEP    = 3'd2,
		REG_FLOOR   = 3'd3,
		REG_CEILING = 3'd4,
		REG_CLOCK   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_CONT  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2,
		EV_FOUND = 2'd3
	} ev_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// window length clamped to [2, MAX_WINDOW]
	function automatic logic [WIN_W-1:0] eff_window(input logic [7:0] wl);
		logic [WIN_W-1:0] w;
		w = WIN_W'(wl);
		if (wl < 8'd2)
			w = WIN_W'(2);
		else if (WIN_W'(wl) > WIN_W'(MAX_WINDOW) || (WIN_W < 8 && wl > 8'(MAX_WINDOW)))
			w = WIN_W'(MAX_WINDOW);
		return w;
	endfunction

	// floor(r*95/100) <= s <= floor(r*105/100), without a divide
	function automatic logic near_ref(input logic [SAMPLE_BITS-1:0] s,
	                                  input logic [SAMPLE_BITS-1:0] r);
		logic [MATCH_W-1:0] s100;
		logic [MATCH_W-1:0] r95;
		logic [MATCH_W-1:0] r105;
		s100 = MATCH_W'(s) * MATCH_W'(100);
		r95  = MATCH_W'(r) * MATCH_W'(95);
		r105 = MATCH_W'(r) * MATCH_W'(105);
		return (r95 <= s100 + MATCH_W'(99)) && (s100 <= r105);
	endfunction

endpackage

// ===== hw/rtl/sample_period_search_freq_meter_core.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   sample
// out       out  out_valid / out_ready event_res, period_out, frequency
// cfg       in   cfg_we                cfg_index, cfg_data
//
// an item passes from input transfer through the compare and finish states to
// the output register, and through the divide state too when the window closes
// on a match: the restoring divider produces one quotient bit per cycle.
// reset loads the register defaults and clears sample index and reference.
// one item is worked at a time; a finished result waits in the output
// register while the next sample is taken.

module sample_period_search_freq_meter_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [spfm_pkg::SAMPLE_BITS-1:0]        sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [1:0]                              event_res,
	output logic [spfm_pkg::PERIOD_W-1:0]           period_out,
	output logic [spfm_pkg::FREQ_W-1:0]             frequency,
	input  logic                                    cfg_we,
	input  logic [spfm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [spfm_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int PW = spfm_pkg::PERIOD_W;

	spfm_pkg::state_t                  state_q;
	logic [7:0]                        window_q;
	logic [spfm_pkg::STEP_W-1:0]       step_q;
	logic [PW-1:0]                     floor_q;
	logic [PW-1:0]                     ceil_q;
	logic [spfm_pkg::CLK_W-1:0]        clock_q;

	logic [spfm_pkg::SAMPLE_BITS-1:0]  ref_q;
	logic [spfm_pkg::IDX_W-1:0]        idx_q;
	logic [PW-1:0]                     pw_q;
	logic [spfm_pkg::SAMPLE_BITS-1:0]  sample_q;
	spfm_pkg::ev_t                     ev_q;
	logic [spfm_pkg::FREQ_W-1:0]       freq_q;

	logic                              out_valid_q;
	spfm_pkg::ev_t                     out_ev_q;
	logic [PW-1:0]                     out_pw_q;
	logic [spfm_pkg::FREQ_W-1:0]       out_freq_q;

	logic [spfm_pkg::WIN_W-1:0]        win;
	logic                              match;
	logic                              not_last;
	logic [PW:0]                       floor_plus;
	logic [PW:0]                       pw_plus;
	logic [PW-1:0]                     pw_short;
	logic [PW-1:0]                     pw_long;
	logic                              in_xfer;
	logic                              div_start;
	logic [spfm_pkg::DIVISOR_W-1:0]    divisor;
	logic [spfm_pkg::CLK_W-1:0]        quotient;
	spfm_pkg::div_stat_t               div_stat;
	logic                              out_free;

	// window decision
	assign win      = spfm_pkg::eff_window(window_q);
	assign match    = spfm_pkg::near_ref(sample_q, ref_q);
	assign not_last = spfm_pkg::WIN_W'(idx_q) < win - spfm_pkg::WIN_W'(1);

	// period adjustment, clamped at floor and ceiling
	assign floor_plus = {1'b0, floor_q} + (PW+1)'(step_q);
	assign pw_plus    = {1'b0, pw_q} + (PW+1)'(step_q);
	always_comb begin
		pw_short = pw_q;
		if (pw_q > floor_q) begin
			if ({1'b0, pw_q} > floor_plus)
				pw_short = pw_q - PW'(step_q);
			else
				pw_short = floor_q;
		end
		pw_long = pw_q;
		if (pw_q < ceil_q) begin
			if (pw_plus < {1'b0, ceil_q})
				pw_long = pw_plus[PW-1:0];
			else
				pw_long = ceil_q;
		end
	end

	assign in_ready  = (state_q == spfm_pkg::ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign div_start = (state_q == spfm_pkg::ST_CMP) && (idx_q != '0) && !not_last && match;
	assign divisor   = spfm_pkg::DIVISOR_W'(pw_q) * spfm_pkg::DIVISOR_W'(win);

	spfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (clock_q),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spfm_pkg::ST_IDLE;
		end else begin
			case (state_q)
				spfm_pkg::ST_IDLE: if (in_xfer) state_q <= spfm_pkg::ST_CMP;
				spfm_pkg::ST_CMP:  state_q <= div_start ? spfm_pkg::ST_DIV : spfm_pkg::ST_FIN;
				spfm_pkg::ST_DIV:  if (div_stat.done) state_q <= spfm_pkg::ST_FIN;
				spfm_pkg::ST_FIN:  if (out_free) state_q <= spfm_pkg::ST_IDLE;
				default:           state_q <= spfm_pkg::ST_IDLE;
			endcase
		end
	end

	// configuration registers and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= spfm_pkg::RST_WINDOW;
			step_q   <= spfm_pkg::RST_STEP;
			floor_q  <= spfm_pkg::RST_FLOOR;
			ceil_q   <= spfm_pkg::RST_CEILING;
			clock_q  <= spfm_pkg::RST_CLOCK;
			ref_q    <= '0;
			idx_q    <= '0;
			pw_q     <= spfm_pkg::RST_START;
		end else if (cfg_we) begin
			case (cfg_index)
				spfm_pkg::REG_WINDOW:  window_q <= cfg_data[7:0];
				spfm_pkg::REG_START:   pw_q     <= cfg_data[PW-1:0];
				spfm_pkg::REG_STEP:    step_q   <= cfg_data[spfm_pkg::STEP_W-1:0];
				spfm_pkg::REG_FLOOR:   floor_q  <= cfg_data[PW-1:0];
				spfm_pkg::REG_CEILING: ceil_q   <= cfg_data[PW-1:0];
				spfm_pkg::REG_CLOCK:   clock_q  <= cfg_data[spfm_pkg::CLK_W-1:0];
				default: ;
			endcase
		end else if (state_q == spfm_pkg::ST_CMP) begin
			if (idx_q == '0) begin
				ref_q <= sample_q;
				idx_q <= spfm_pkg::IDX_W'(1);
			end else if (not_last) begin
				if (match) begin
					idx_q <= '0;
					pw_q  <= pw_short;
				end else begin
					idx_q <= idx_q + spfm_pkg::IDX_W'(1);
				end
			end else begin
				idx_q <= '0;
				if (!match)
					pw_q <= pw_long;
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (in_xfer)
			sample_q <= sample;
		if (state_q == spfm_pkg::ST_CMP) begin
			freq_q <= '0;
			if (idx_q == '0)
				ev_q <= spfm_pkg::EV_CONT;
			else if (not_last)
				ev_q <= match ? spfm_pkg::EV_SHORT : spfm_pkg::EV_CONT;
			else
				ev_q <= match ? spfm_pkg::EV_FOUND : spfm_pkg::EV_LONG;
		end else if (state_q == spfm_pkg::ST_DIV && div_stat.done) begin
			// saturate a quotient wider than the result field
			if (quotient[spfm_pkg::CLK_W-1:spfm_pkg::FREQ_W] != '0)
				freq_q <= '1;
			else
				freq_q <= quotient[spfm_pkg::FREQ_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == spfm_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == spfm_pkg::ST_FIN && out_free) begin
			out_ev_q   <= ev_q;
			out_pw_q   <= pw_q;
			out_freq_q <= freq_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_res  = out_ev_q;
	assign period_out = out_pw_q;
	assign frequency  = out_freq_q;

endmodule

// ===== hw/rtl/spfm_div.sv =====
`timescale 1ns / 1ps

module spfm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [spfm_pkg::CLK_W-1:0]          dividend,
	input  logic [spfm_pkg::DIVISOR_W-1:0]      divisor,
	output spfm_pkg::div_stat_t                 stat,
	output logic [spfm_pkg::CLK_W-1:0]          quotient
);

	localparam int CNT_W = $clog2(spfm_pkg::CLK_W);
	localparam int REM_W = spfm_pkg::DIVISOR_W + 1;

	logic                             busy_q;
	logic                             done_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [spfm_pkg::DIVISOR_W-1:0]   dvs_q;
	logic [spfm_pkg::DIVISOR_W-1:0]   rem_q;
	logic [spfm_pkg::CLK_W-1:0]       quo_q;
	logic [REM_W-1:0]                 rem_shift;
	logic                             fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_shift = {rem_q, quo_q[spfm_pkg::CLK_W-1]};
	assign fits      = rem_shift >= REM_W'(dvs_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(spfm_pkg::CLK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// datapath, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits)
				rem_q <= spfm_pkg::DIVISOR_W'(rem_shift - REM_W'(dvs_q));
			else
				rem_q <= rem_shift[spfm_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[spfm_pkg::CLK_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== hw/rtl/spfm_checker.sv =====
`timescale 1ns / 1ps

module spfm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [1:0]                           event_res,
	input logic [spfm_pkg::PERIOD_W-1:0]        period_out,
	input logic [spfm_pkg::FREQ_W-1:0]          frequency
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res)
			&& $stable(period_out) && $stable(frequency))
		else $error("result changed while stalled");

	// frequency is only reported with a found event
	a_freq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res != spfm_pkg::EV_FOUND) |-> frequency == '0)
		else $error("frequency set without found event");

	// one item at a time: busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while item in work");

	// a result cannot appear sooner than the compare step allows
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind sample_period_search_freq_meter_core spfm_checker u_spfm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_res  (event_res),
	.period_out (period_out),
	.frequency  (frequency)
);
